### hw/rtl/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg: shared types and constants for the byte pattern search block
// Item structs for both channels, register indexes, result kind codes.
// ----------------------------------------------------------------------------
package bps_pkg;

  // Needle storage is four 64-bit registers, eight bytes each
  localparam int unsigned NeedleCap   = 32;
  localparam int unsigned NeedleRegs  = 4;
  localparam int unsigned CfgWidth    = 64;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned LenRegWidth = 6;

  // Configuration register indexes
  localparam logic [CfgIdxWidth-1:0] RegNeedle0   = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegNeedle1   = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegNeedle2   = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegNeedle3   = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegNeedleLen = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegAllowPart = 3'd5;

  // Result kinds
  localparam logic [1:0] KindNone     = 2'd0;
  localparam logic [1:0] KindFull     = 2'd1;
  localparam logic [1:0] KindPartial  = 2'd2;
  localparam logic [1:0] KindReserved = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  match_kind;
    logic [31:0] match_offset;
    logic [5:0]  match_length;
  } out_item_t;

  // Control of the report stage
  typedef struct packed {
    logic adv;   // stage holds an item and moves on this cycle
    logic last;  // that item closes its buffer
  } stage_ctl_t;

endpackage

### hw/rtl/bps_cell.sv
// ----------------------------------------------------------------------------
// bps_cell: one cell of the prefix match chain
// Holds the hit bit for one needle position and hands it to the next cell.
// ----------------------------------------------------------------------------
module bps_cell (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] needle_byte_i,
  input  logic       active_i,
  input  logic       hit_prev_i,
  output logic       hit_o
);
  import bps_pkg::*;

  logic hit_d;
  logic hit_q;

  // prefix of length k+1 ends here when prefix k ended on the prior byte
  assign hit_d = hit_prev_i & active_i & (data_byte_i == needle_byte_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (en_i) begin
      hit_q <= hit_d;
    end
  end

  assign hit_o = hit_q;

endmodule

### hw/rtl/bps_report.sv
// ----------------------------------------------------------------------------
// bps_report: full match tracking and result forming
// Watches the chain's hit bits, keeps the first full match, builds the result.
// ----------------------------------------------------------------------------
module bps_report #(
  parameter int unsigned NumCells   = 32,
  parameter int unsigned OffsetBits = 32,
  parameter int unsigned LenW       = 6,
  parameter int unsigned IdxW       = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bps_pkg::stage_ctl_t       ctl_i,
  input  logic [NumCells-1:0]       hits_i,
  input  logic [OffsetBits-1:0]     pos_i,
  input  logic [LenW-1:0]           eff_len_i,
  input  logic                      allow_partial_i,
  output logic                      res_valid_o,
  output bps_pkg::out_item_t        res_o
);
  import bps_pkg::*;

  logic                  full_found_d, full_found_q;
  logic [OffsetBits-1:0] found_off_d, found_off_q;
  logic                  hit_full;
  logic [OffsetBits-1:0] new_off;
  logic [OffsetBits-1:0] part_off;
  logic [LenW-1:0]       plen;
  logic [63:0]           off_wide;

  assign hit_full = hits_i[IdxW'(eff_len_i - LenW'(1))];
  assign new_off  = pos_i - OffsetBits'(eff_len_i) + OffsetBits'(1);
  assign part_off = pos_i - OffsetBits'(plen) + OffsetBits'(1);

  // longest needle prefix that is a tail of the buffer, shorter than needle
  always_comb begin
    plen = '0;
    for (int k = 0; k < NumCells; k++) begin
      if (hits_i[k] && ((LenW'(k) + LenW'(1)) < eff_len_i)) begin
        plen = LenW'(k + 1);
      end
    end
  end

  always_comb begin
    res_o    = '0;
    off_wide = '0;
    if (full_found_q || hit_full) begin
      off_wide            = 64'(full_found_q ? found_off_q : new_off);
      res_o.match_kind    = KindFull;
      res_o.match_offset  = off_wide[31:0];
      res_o.match_length  = 6'(eff_len_i);
    end else if (allow_partial_i && (plen != '0)) begin
      off_wide            = 64'(part_off);
      res_o.match_kind    = KindPartial;
      res_o.match_offset  = off_wide[31:0];
      res_o.match_length  = 6'(plen);
    end
  end

  assign res_valid_o = ctl_i.adv & ctl_i.last;

  always_comb begin
    full_found_d = full_found_q;
    found_off_d  = found_off_q;
    if (ctl_i.adv) begin
      if (ctl_i.last) begin
        full_found_d = 1'b0;
        found_off_d  = '0;
      end else if (!full_found_q && hit_full) begin
        full_found_d = 1'b1;
        found_off_d  = new_off;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_found_q <= 1'b0;
      found_off_q  <= '0;
    end else begin
      full_found_q <= full_found_d;
      found_off_q  <= found_off_d;
    end
  end

endmodule

### hw/rtl/byte_pattern_search_partial_tail.sv
// ----------------------------------------------------------------------------
// byte_pattern_search_partial_tail: streaming needle search over one buffer
// Shift-and search with a row of compare cells; one result per buffer.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-------------------------------------
//  in      | in  | in_valid_i / in_stall_o  | in_item_i  (data_byte, is_last)
//  out     | out | out_valid_o / out_stall_i| out_item_o (kind, offset, length)
//  cfg     | in  | cfg_we_i                 | cfg_index_i, cfg_data_i
//
//  One byte per cycle while in_stall_o is low. A byte enters the cell row on the
//  accepting edge; the report stage then judges the row's hits and, unless held
//  by a full queue, writes the result of a last byte into the output queue,
//  which raises out_valid_o.
//  The output queue holds two results, so a stalled consumer does not stop
//  input until both slots are full and a closing byte waits in the report stage.
//  Reset clears the hit row, the position counter, the first-match record and
//  the queue; the needle resets to zero bytes with length one, partial off.
//
module byte_pattern_search_partial_tail #(
  parameter int unsigned MAX_NEEDLE  = 32,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  bps_pkg::in_item_t                     in_item_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output bps_pkg::out_item_t                    out_item_o,
  input  logic                                  cfg_we_i,
  input  logic [bps_pkg::CfgIdxWidth-1:0]       cfg_index_i,
  input  logic [bps_pkg::CfgWidth-1:0]          cfg_data_i
);
  import bps_pkg::*;

  // needle positions beyond the storage never match
  localparam int unsigned NumCells = (MAX_NEEDLE < NeedleCap) ? MAX_NEEDLE : NeedleCap;
  localparam int unsigned LenW     = $clog2(NumCells + 1);
  localparam int unsigned IdxW     = (NumCells > 1) ? $clog2(NumCells) : 1;

  // ---------------- configuration registers ----------------
  logic [NeedleRegs*CfgWidth-1:0] needle_q;
  logic [LenRegWidth-1:0]         len_q;
  logic                           allow_q;
  logic [LenW-1:0]                eff_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_q <= '0;
      len_q    <= LenRegWidth'(1);
      allow_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegNeedle0:   needle_q[0*CfgWidth +: CfgWidth] <= cfg_data_i;
        RegNeedle1:   needle_q[1*CfgWidth +: CfgWidth] <= cfg_data_i;
        RegNeedle2:   needle_q[2*CfgWidth +: CfgWidth] <= cfg_data_i;
        RegNeedle3:   needle_q[3*CfgWidth +: CfgWidth] <= cfg_data_i;
        RegNeedleLen: len_q   <= cfg_data_i[LenRegWidth-1:0];
        RegAllowPart: allow_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // zero length acts as one; saturate at the cell count
  always_comb begin
    if (len_q == '0) begin
      eff_len = LenW'(1);
    end else if (len_q > LenRegWidth'(NumCells)) begin
      eff_len = LenW'(NumCells);
    end else begin
      eff_len = LenW'(len_q);
    end
  end

  // ---------------- input stage and cell row ----------------
  logic                   a_fire;
  logic                   b_hold;
  logic                   start_q;   // previous accepted byte closed a buffer
  logic [OFFSET_BITS-1:0] pos_q;
  logic [NumCells-1:0]    hits;

  assign in_stall_o = b_hold;
  assign a_fire     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b1;
      pos_q   <= '0;
    end else if (a_fire) begin
      start_q <= in_item_i.is_last;
      pos_q   <= in_item_i.is_last ? '0 : pos_q + OFFSET_BITS'(1);
    end
  end

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    logic hit_prev;
    if (k == 0) begin : g_head
      assign hit_prev = 1'b1;
    end else begin : g_link
      assign hit_prev = hits[k-1] & ~start_q;
    end

    bps_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .en_i          (a_fire),
      .data_byte_i   (in_item_i.data_byte),
      .needle_byte_i (needle_q[8*k +: 8]),
      .active_i      (LenW'(k) < eff_len),
      .hit_prev_i    (hit_prev),
      .hit_o         (hits[k])
    );
  end

  // ---------------- report stage ----------------
  logic                   valid_s_q;
  logic                   last_s_q;
  logic [OFFSET_BITS-1:0] pos_s_q;
  stage_ctl_t             s_ctl;
  logic                   res_valid;
  out_item_t              res_item;

  // output queue
  out_item_t              fifo_q [2];
  logic                   wr_ptr_q, rd_ptr_q;
  logic [1:0]             count_q;
  logic                   push, pop;

  // a closing byte waits in the report stage while the queue is full
  assign b_hold = valid_s_q & last_s_q & (count_q == 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_s_q <= 1'b0;
      last_s_q  <= 1'b0;
    end else if (!b_hold) begin
      valid_s_q <= a_fire;
      if (a_fire) begin
        last_s_q <= in_item_i.is_last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      pos_s_q <= pos_q;
    end
  end

  assign s_ctl.adv  = valid_s_q & ~b_hold;
  assign s_ctl.last = last_s_q;

  bps_report #(
    .NumCells   (NumCells),
    .OffsetBits (OFFSET_BITS),
    .LenW       (LenW),
    .IdxW       (IdxW)
  ) u_report (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (s_ctl),
    .hits_i          (hits),
    .pos_i           (pos_s_q),
    .eff_len_i       (eff_len),
    .allow_partial_i (allow_q),
    .res_valid_o     (res_valid),
    .res_o           (res_item)
  );

  // ---------------- output queue ----------------
  assign push = res_valid;
  assign pop  = (count_q != 2'd0) & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res_item;
    end
  end

  assign out_valid_o = (count_q != 2'd0);
  assign out_item_o  = fifo_q[rd_ptr_q];

`ifndef SYNTHESIS
  // the report stage never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (count_q != 2'd2))
    else $error("result pushed into full output queue");

  // queue occupancy stays within its two slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("output queue count out of range");

  // a closing byte reaches the report stage on the next edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_fire && in_item_i.is_last) |=> (valid_s_q && last_s_q))
    else $error("closing byte lost before report stage");

  // a delivered result never carries the unused kind code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.match_kind != KindReserved))
    else $error("result with reserved kind");
`endif

endmodule
